### design/mlsf_pkg.sv
// Shared types and constants for the MAC learning switch forwarding block.
// Holds beat payload structs, controller/datapath command and status structs.
// No dependencies.
package mlsf_pkg;

  localparam int PORTS         = 8;
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int MAC_W         = 48;
  localparam int PORT_W        = 3;
  localparam int TIME_W        = 32;
  localparam int AGE_W         = 31;
  localparam int MASK_W        = 8;
  localparam int CNT_W         = 4;

  localparam logic [AGE_W-1:0] AGE_RESET = AGE_W'(300);
  localparam int GROUP_BIT = 40;

  localparam logic [1:0] FUNC_RX   = 2'd0;
  localparam logic [1:0] FUNC_TX   = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] KIND_HOST  = 2'd0;
  localparam logic [1:0] KIND_BCAST = 2'd1;
  localparam logic [1:0] KIND_MCAST = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [1:0] REG_LEARN_ENABLE = 2'd0;
  localparam logic [1:0] REG_AGE_LIMIT    = 2'd1;
  localparam logic [1:0] REG_OWN_MAC      = 2'd2;
  localparam logic [1:0] REG_PORT_COUNT   = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       frame_kind;
    logic [2:0]       in_port;
    logic [MAC_W-1:0] src_mac;
    logic [MAC_W-1:0] dst_mac;
  } in_item_t;

  typedef struct packed {
    logic              local_deliver;
    logic [MASK_W-1:0] out_ports;
    logic              flooded;
    logic              table_hit;
  } out_item_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic load;
    logic learn_start;
    logic learn_write;
    logic look_start;
    logic look_end;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_learn;
    logic need_lookup;
    logic scan_idle;
  } status_t;

endpackage

### design/mlsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mlsf_datapath.sv
// Datapath: configuration registers, time counter, entry valid bits, table RAM,
// the table scan unit and the result register. Depends on mlsf_pkg, mlsf_ram.
module mlsf_datapath import mlsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_data,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  input  cmd_t        cmd,
  output status_t     stat
);

  logic             learn_enable;
  logic [AGE_W-1:0] age_limit;
  logic [MAC_W-1:0] own_mac;
  logic [CNT_W-1:0] port_count;
  logic [TIME_W-1:0] current_time;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  in_item_t item;

  logic             scan_busy, scan_pend, scan_on_dst;
  logic [IDX_W-1:0] scan_cnt, pend_idx;
  logic             match_found, match_live, free_found;
  logic [IDX_W-1:0] match_idx, free_idx;
  logic [PORT_W-1:0] match_port;
  logic             lk_hit;
  logic [PORT_W-1:0] lk_port;

  entry_t           rd_entry, wr_entry;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [1:0]       reg_idx;
  logic             cfg_wr;

  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LEARN_ENABLE: prdata = 64'(learn_enable);
      REG_AGE_LIMIT:    prdata = 64'(age_limit);
      REG_OWN_MAC:      prdata = 64'(own_mac);
      REG_PORT_COUNT:   prdata = 64'(port_count);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_enable <= 1'b1;
      age_limit    <= AGE_RESET;
      own_mac      <= '0;
      port_count   <= CNT_W'(8);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LEARN_ENABLE: learn_enable <= pwdata[0];
        REG_AGE_LIMIT:    age_limit    <= pwdata[AGE_W-1:0];
        REG_OWN_MAC:      own_mac      <= pwdata[MAC_W-1:0];
        REG_PORT_COUNT:   port_count   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item decode for the controller.
  always_comb begin
    stat.need_learn  = 1'b0;
    stat.need_lookup = 1'b0;
    if (item.func == FUNC_RX) begin
      if (item.frame_kind == KIND_BCAST || item.frame_kind == KIND_MCAST) begin
        stat.need_learn = 1'b1;
      end else if (item.frame_kind == KIND_OTHER && item.dst_mac != own_mac) begin
        stat.need_learn  = 1'b1;
        stat.need_lookup = 1'b1;
      end
    end else if (item.func == FUNC_TX) begin
      stat.need_lookup = !item.dst_mac[GROUP_BIT];
    end
    stat.scan_idle = !scan_busy && !scan_pend;
  end

  // Entry liveness: expiry minus now lies in 1 .. 2^31-1.
  logic [TIME_W-1:0] diff;
  logic              rd_live, rd_valid;
  logic [MAC_W-1:0]  scan_key;
  assign diff     = rd_entry.expiry - current_time;
  assign rd_live  = (diff != '0) && !diff[TIME_W-1];
  assign rd_valid = entry_valid[pend_idx];
  assign scan_key = scan_on_dst ? item.dst_mac : item.src_mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy   <= 1'b0;
      scan_pend   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      scan_pend <= scan_busy;
      if (cmd.learn_start || cmd.look_start) begin
        scan_busy   <= 1'b1;
        scan_cnt    <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        scan_on_dst <= cmd.look_start;
      end else if (scan_busy) begin
        scan_cnt <= scan_cnt + 1'b1;
        if (scan_cnt == IDX_W'(TABLE_ENTRIES - 1)) begin
          scan_busy <= 1'b0;
        end
      end
      pend_idx <= scan_cnt;
      if (scan_pend) begin
        if (rd_valid && rd_entry.mac == scan_key && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= pend_idx;
          match_live  <= rd_live;
          match_port  <= rd_entry.port;
        end
        if ((!rd_valid || !rd_live) && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= pend_idx;
        end
      end
    end
  end

  assign ram_we    = cmd.learn_write && learn_enable && (match_found || free_found);
  assign ram_waddr = match_found ? match_idx : free_idx;
  assign wr_entry  = '{mac: item.src_mac, port: item.in_port,
                       expiry: current_time + TIME_W'(age_limit)};

  mlsf_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (scan_cnt),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      current_time <= '0;
      lk_hit       <= 1'b0;
    end else begin
      if (cmd.load) begin
        lk_hit <= 1'b0;
      end
      if (ram_we) begin
        entry_valid[ram_waddr] <= 1'b1;
      end
      if (cmd.look_end && learn_enable && match_found) begin
        if (match_live) begin
          lk_hit  <= 1'b1;
          lk_port <= match_port;
        end else begin
          entry_valid[match_idx] <= 1'b0;
        end
      end
      if (cmd.finish && item.func == FUNC_TICK) begin
        current_time <= current_time + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // Result forming.
  logic [CNT_W-1:0]  n_ports;
  logic [MASK_W:0]   all_wide;
  logic [MASK_W-1:0] all_mask, ing_mask, hit_mask;
  logic              hit_ok;
  out_item_t         res;

  always_comb begin
    n_ports = port_count;
    if (n_ports > CNT_W'(PORTS)) n_ports = CNT_W'(PORTS);
    if (n_ports > CNT_W'(MASK_W)) n_ports = CNT_W'(MASK_W);
    all_wide = ((MASK_W+1)'(1) << n_ports) - (MASK_W+1)'(1);
    all_mask = all_wide[MASK_W-1:0];
    ing_mask = MASK_W'(1) << item.in_port;
    hit_mask = MASK_W'(1) << lk_port;
    hit_ok   = lk_hit && ({1'b0, lk_port} < n_ports);
    res      = '0;
    if (item.func == FUNC_RX) begin
      case (item.frame_kind)
        KIND_HOST: res.local_deliver = (item.dst_mac == own_mac);
        KIND_BCAST, KIND_MCAST: begin
          res.local_deliver = 1'b1;
          res.out_ports     = all_mask & ~ing_mask;
          res.flooded       = 1'b1;
        end
        default: begin
          if (item.dst_mac == own_mac) begin
            res.local_deliver = 1'b1;
          end else begin
            res.table_hit = hit_ok;
            if (hit_ok && lk_port != item.in_port) begin
              res.out_ports = hit_mask;
            end else begin
              res.out_ports = all_mask & ~ing_mask;
              res.flooded   = 1'b1;
            end
          end
        end
      endcase
    end else if (item.func == FUNC_TX) begin
      if (hit_ok) begin
        res.table_hit = 1'b1;
        res.out_ports = hit_mask;
      end else begin
        res.out_ports = all_mask;
        res.flooded   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= res;
    end
  end

endmodule

### design/mlsf_ctrl.sv
// Controller: sequences decode, learn scan and write, lookup scan and result.
// Depends on mlsf_pkg.
module mlsf_ctrl import mlsf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE, DISPATCH, LEARN_GO, LEARN_WAIT, LEARN_WR,
    LOOK_GO, LOOK_WAIT, LOOK_END, FINISH
  } state_t;

  state_t state, state_next;
  logic   fin_fire;

  assign fin_fire = (state == FINISH) && (!out_valid || out_ready);

  always_comb begin
    cmd             = '0;
    cmd.load        = in_valid && in_ready;
    cmd.learn_start = (state == LEARN_GO);
    cmd.learn_write = (state == LEARN_WR);
    cmd.look_start  = (state == LOOK_GO);
    cmd.look_end    = (state == LOOK_END);
    cmd.finish      = fin_fire;
    state_next      = state;
    unique case (state)
      IDLE:       if (in_valid) state_next = DISPATCH;
      DISPATCH: begin
        if (stat.need_learn) state_next = LEARN_GO;
        else if (stat.need_lookup) state_next = LOOK_GO;
        else state_next = FINISH;
      end
      LEARN_GO:   state_next = LEARN_WAIT;
      LEARN_WAIT: if (stat.scan_idle) state_next = LEARN_WR;
      LEARN_WR:   state_next = stat.need_lookup ? LOOK_GO : FINISH;
      LOOK_GO:    state_next = LOOK_WAIT;
      LOOK_WAIT:  if (stat.scan_idle) state_next = LOOK_END;
      LOOK_END:   state_next = FINISH;
      FINISH:     if (fin_fire) state_next = IDLE;
      default:    state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == IDLE);
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/mac_learning_switch_forward_top.sv
// Ethernet learning bridge with an aging 64-entry MAC table.
// A tick, host frame or group send goes from accept through decode to the result;
// a learn or a lookup adds one full table scan over all TABLE_ENTRIES entries
// each, so an other-host frame takes both scans. One item at a time;
// the single read port of the table RAM sets the scan length. Synchronous reset
// clears valid bits and time and resets registers; no clearing pass is needed.
module mac_learning_switch_forward_top import mlsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cmd_t    cmd;
  status_t stat;

  assign pready = 1'b1;

  mlsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlsf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  // A new beat is only taken with the scan unit at rest.
  assert property (@(posedge clk) disable iff (rst) in_ready |-> stat.scan_idle)
    else $error("input ready while a table scan runs");

  // Accepting a beat closes the input until its result is formed.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.learn_start, cmd.learn_write, cmd.look_start,
              cmd.look_end, cmd.finish}))
    else $error("more than one command at once");

endmodule
